// ===== hw/rtl/tpsc_pkg.sv =====
`default_nettype none
package tpsc_pkg;

  // Default build values
  localparam int SLOTS_DEF         = 8;
  localparam int VRAM_BASE_COL_DEF = 512;
  localparam int PAGE_WORDS_DEF    = 64;

  // Widest slot index the block supports (up to 16 slots)
  localparam int SLOT_IDX_W = 4;

  localparam logic [31:0] STAMP_NONE = 32'hffff_ffff;

  // Request commands
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FRAME  = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_ALLOC     = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_BAD_ATLAS = 3'd3;
  localparam logic [2:0] ST_FRAME     = 3'd4;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  typedef struct packed {
    logic        command;
    logic [15:0] atlas_id;
    logic [2:0]  page_col;
    logic [1:0]  page_row;
    logic        depth_mode;
  } tpsc_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_index;
    logic [9:0] vram_col;
  } tpsc_rsp_t;

  // Page tag held per slot
  typedef struct packed {
    logic [15:0] atlas;
    logic [2:0]  col;
    logic [1:0]  row;
    logic        depth;
  } tag_t;

  // Running outcome of the slot scan
  typedef struct packed {
    logic      hit;
    slot_idx_t hit_idx;
    logic      inv;
    slot_idx_t inv_idx;
    logic      vic;
    slot_idx_t vic_idx;
  } scan_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tpsc_slot_store.sv =====
`default_nettype none
module tpsc_slot_store #(
  parameter int SLOTS = tpsc_pkg::SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IDX_W-1:0]       rd_idx,
  output logic                        rd_valid,
  output tpsc_pkg::tag_t              rd_tag,
  output logic [31:0]                 rd_stamp,
  input  wire logic                   wr_en,
  input  wire logic                   wr_fill,
  input  wire logic [IDX_W-1:0]       wr_idx,
  input  wire tpsc_pkg::tag_t         wr_tag,
  input  wire logic [31:0]            wr_stamp
);
  import tpsc_pkg::*;

  logic [SLOTS-1:0] valid_r;
  tag_t             tag_r   [SLOTS];
  logic [31:0]      stamp_r [SLOTS];

  // Valid bits: cleared on reset, set on fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en && wr_fill) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // Tag and stamp storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_r[wr_idx] <= wr_stamp;
      if (wr_fill) begin
        tag_r[wr_idx] <= wr_tag;
      end
    end
  end

  // Scan read port
  assign rd_valid = valid_r[rd_idx];
  assign rd_tag   = tag_r[rd_idx];
  assign rd_stamp = stamp_r[rd_idx];

endmodule
`default_nettype wire

// ===== hw/rtl/tpsc_scan_unit.sv =====
`default_nettype none
module tpsc_scan_unit (
  input  wire logic                clk,
  input  wire logic                step,
  input  wire logic                first,
  input  wire tpsc_pkg::slot_idx_t cur_idx,
  input  wire logic                cur_valid,
  input  wire tpsc_pkg::tag_t      cur_tag,
  input  wire logic [31:0]         cur_stamp,
  input  wire tpsc_pkg::tag_t      req_tag,
  input  wire logic [31:0]         frame,
  output tpsc_pkg::scan_res_t      res
);
  import tpsc_pkg::*;

  scan_res_t   res_r,    res_nxt;
  logic [31:0] oldest_r, oldest_nxt;
  scan_res_t   base;
  logic [31:0] oldest_base;

  // One slot per step: tag match, first invalid, oldest unpinned stamp
  always_comb begin
    base        = first ? '0 : res_r;
    oldest_base = first ? STAMP_NONE : oldest_r;
    res_nxt     = base;
    oldest_nxt  = oldest_base;
    if (!base.hit && cur_valid && (cur_tag == req_tag)) begin
      res_nxt.hit     = 1'b1;
      res_nxt.hit_idx = cur_idx;
    end
    if (!base.inv && !cur_valid) begin
      res_nxt.inv     = 1'b1;
      res_nxt.inv_idx = cur_idx;
    end
    // strict less keeps the lowest index on a tie
    if (cur_valid && (cur_stamp != frame) && (cur_stamp < oldest_base)) begin
      res_nxt.vic     = 1'b1;
      res_nxt.vic_idx = cur_idx;
      oldest_nxt      = cur_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r    <= res_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== hw/rtl/texture_page_slot_cache.sv =====
// Lookup: the request is scanned in S_SCAN, one slot checked per cycle by
// the shared tag/stamp compare unit, then resolved in S_DONE. A frame
// request goes straight to S_DONE. The result strobe is registered from S_DONE.
// busy stays high until the result strobe; a new request may start then.
// Reset (synchronous, rst_n low): all slots invalid, frame counter 1,
// atlas count 0. Results cannot be stalled by the receiver.
`default_nettype none
module texture_page_slot_cache #(
  parameter int SLOTS         = tpsc_pkg::SLOTS_DEF,
  parameter int VRAM_BASE_COL = tpsc_pkg::VRAM_BASE_COL_DEF,
  parameter int PAGE_WORDS    = tpsc_pkg::PAGE_WORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire tpsc_pkg::tpsc_req_t in_req,
  output logic                    out_strobe,
  output tpsc_pkg::tpsc_rsp_t     out_rsp,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);
  import tpsc_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  tpsc_req_t        req_r;
  logic [31:0]      frame_r, frame_nxt;
  logic [15:0]      atlas_count_r;
  logic             out_strobe_r;
  tpsc_rsp_t        out_rsp_r, rsp_nxt;

  tag_t             req_tag;
  logic             rd_valid;
  tag_t             rd_tag;
  logic [31:0]      rd_stamp;
  scan_res_t        scan;
  logic             wr_en, wr_fill;
  slot_idx_t        sel_idx;
  logic             accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign req_tag   = '{atlas: req_r.atlas_id, col: req_r.page_col,
                       row: req_r.page_row, depth: req_r.depth_mode};

  tpsc_slot_store #(.SLOTS(SLOTS)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r),
    .rd_valid (rd_valid),
    .rd_tag   (rd_tag),
    .rd_stamp (rd_stamp),
    .wr_en    (wr_en),
    .wr_fill  (wr_fill),
    .wr_idx   (sel_idx[IDX_W-1:0]),
    .wr_tag   (req_tag),
    .wr_stamp (frame_r)
  );

  tpsc_scan_unit u_scan (
    .clk       (clk),
    .step      (state_r == S_SCAN),
    .first     (idx_r == '0),
    .cur_idx   (SLOT_IDX_W'(idx_r)),
    .cur_valid (rd_valid),
    .cur_tag   (rd_tag),
    .cur_stamp (rd_stamp),
    .req_tag   (req_tag),
    .frame     (frame_r),
    .res       (scan)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (start) begin
          state_nxt = (in_req.command == CMD_FRAME) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Resolve the request in S_DONE, after the scan for a lookup
  always_comb begin
    frame_nxt = frame_r;
    wr_en     = 1'b0;
    wr_fill   = 1'b0;
    sel_idx   = '0;
    rsp_nxt   = '0;
    if (req_r.command == CMD_FRAME) begin
      frame_nxt = frame_r + 32'd1;
      if (frame_nxt == '0) begin
        frame_nxt = 32'd1;
      end
      rsp_nxt.status = ST_FRAME;
    end else if (scan.hit) begin
      wr_en          = 1'b1;
      sel_idx        = scan.hit_idx;
      rsp_nxt.status = ST_HIT;
    end else if (req_r.atlas_id >= atlas_count_r) begin
      rsp_nxt.status = ST_BAD_ATLAS;
    end else if (scan.inv || scan.vic) begin
      wr_en          = 1'b1;
      wr_fill        = 1'b1;
      sel_idx        = scan.inv ? scan.inv_idx : scan.vic_idx;
      rsp_nxt.status = ST_ALLOC;
    end else begin
      rsp_nxt.status = ST_NO_SLOT;
    end
    if (wr_en) begin
      rsp_nxt.slot_index = sel_idx;
      rsp_nxt.vram_col   = 10'(VRAM_BASE_COL + int'(sel_idx) * PAGE_WORDS);
    end
    if (state_r != S_DONE) begin
      frame_nxt = frame_r;
      wr_en     = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      idx_r         <= '0;
      frame_r       <= 32'd1;
      atlas_count_r <= '0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      frame_r      <= frame_nxt;
      out_strobe_r <= (state_r == S_DONE);
      if (cfg_valid && cfg_ready) begin
        atlas_count_r <= cfg_data;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (state_r == S_DONE) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule
`default_nettype wire

// ===== bench/tb_texture_page_slot_cache.sv =====
`timescale 1ns / 1ps
module tb_texture_page_slot_cache;
  import tpsc_pkg::*;

  localparam int SLOTS         = SLOTS_DEF;
  localparam int VRAM_BASE_COL = VRAM_BASE_COL_DEF;
  localparam int PAGE_WORDS    = PAGE_WORDS_DEF;
  localparam int IDLE_LIMIT    = 2000;
  localparam int POOL_SIZE     = 12;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  tpsc_req_t   in_req    = '0;
  logic        out_strobe;
  tpsc_rsp_t   out_rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  texture_page_slot_cache #(
    .SLOTS        (SLOTS),
    .VRAM_BASE_COL(VRAM_BASE_COL),
    .PAGE_WORDS   (PAGE_WORDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the slot table, frame counter and atlas limit
  logic        slot_valid [SLOTS];
  tag_t        slot_tag   [SLOTS];
  logic [31:0] slot_stamp [SLOTS];
  logic [31:0] frame_count;
  logic [15:0] atlas_limit;

  tpsc_rsp_t   outcome_q [$];
  tpsc_rsp_t   want_rsp;
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  bit          gap_enable     = 1'b1;
  tag_t        page_pool [POOL_SIZE];

  // Expected outcome of one request; updates the shadow state
  function automatic tpsc_rsp_t predict_slot_outcome(tpsc_req_t req);
    tpsc_rsp_t   rsp;
    tag_t        tag;
    int          victim;
    logic [31:0] oldest;
    rsp = '0;
    if (req.command == CMD_FRAME) begin
      frame_count = frame_count + 32'd1;
      if (frame_count == 32'd0) frame_count = 32'd1;
      rsp.status = ST_FRAME;
      return rsp;
    end
    tag = tag_t'{req.atlas_id, req.page_col, req.page_row, req.depth_mode};
    victim = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (victim < 0 && slot_valid[i] && slot_tag[i] == tag) begin
        slot_stamp[i] = frame_count;
        rsp.status = ST_HIT;
        victim = i;
      end
    end
    if (victim < 0) begin
      if (req.atlas_id >= atlas_limit) begin
        rsp.status = ST_BAD_ATLAS;
        return rsp;
      end
      // first free slot, else oldest unpinned stamp (lowest index on a tie)
      oldest = STAMP_NONE;
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_valid[i]) begin
          victim = i;
          break;
        end
        if (slot_stamp[i] != frame_count && slot_stamp[i] < oldest) begin
          oldest = slot_stamp[i];
          victim = i;
        end
      end
      if (victim < 0) begin
        rsp.status = ST_NO_SLOT;
        return rsp;
      end
      slot_valid[victim] = 1'b1;
      slot_tag[victim]   = tag;
      slot_stamp[victim] = frame_count;
      rsp.status = ST_ALLOC;
    end
    rsp.slot_index = 4'(victim);
    rsp.vram_col   = 10'(VRAM_BASE_COL + victim * PAGE_WORDS);
    return rsp;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status=%0d slot=%0d vram=%0d",
                 $time, out_rsp.status, out_rsp.slot_index, out_rsp.vram_col);
        mismatch_count++;
      end else begin
        want_rsp = outcome_q.pop_front();
        check_field("status", want_rsp.status, out_rsp.status);
        check_field("slot_index", want_rsp.slot_index, out_rsp.slot_index);
        check_field("vram_col", want_rsp.vram_col, out_rsp.vram_col);
      end
    end
  end

  // Watchdog: no request, result or register write for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gap_enable || r < 55) return 0;
    if (r < 93) return $urandom_range(1, SLOTS + 3);
    return $urandom_range(15, 40);
  endfunction

  function automatic tpsc_req_t lookup_req(tag_t t);
    tpsc_req_t req;
    req.command    = CMD_LOOKUP;
    req.atlas_id   = t.atlas;
    req.page_col   = t.col;
    req.page_row   = t.row;
    req.depth_mode = t.depth;
    return req;
  endfunction

  // Frame request with junk in the lookup fields
  function automatic tpsc_req_t frame_req();
    tpsc_req_t req;
    req = tpsc_req_t'($urandom);
    req.command = CMD_FRAME;
    return req;
  endfunction

  // Page mostly inside the atlas limit, sometimes anywhere
  function automatic tag_t random_page(logic [15:0] limit);
    tag_t t;
    if (limit != 0 && $urandom_range(0, 3) != 0) t.atlas = 16'($urandom_range(0, limit - 1));
    else t.atlas = 16'($urandom);
    t.col   = 3'($urandom);
    t.row   = 2'($urandom);
    t.depth = 1'($urandom);
    return t;
  endfunction

  // Issue one request and record its expected result once busy drops
  task automatic send_request(tpsc_req_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    outcome_q.push_back(predict_slot_outcome(req));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0 || busy) @(posedge clk);
    repeat (SLOTS + 2) @(posedge clk);
  endtask

  task automatic write_atlas_count(logic [15:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    atlas_limit = value;
    cfg_valid <= 1'b0;
  endtask

  // Atlas count is zero out of reset: every miss is rejected
  task automatic test_reset_defaults();
    send_request(lookup_req(tag_t'{16'h0000, 3'd0, 2'd0, 1'b0}));
    send_request(tpsc_req_t'('1));
  endtask

  // Fill every slot in one frame with tags differing in single fields,
  // then one more miss finds every slot pinned and a repeat of the first tag hits
  task automatic test_fill_and_pin();
    tag_t fill_tags [9];
    fill_tags = '{tag_t'{16'h0000, 3'd0, 2'd0, 1'b0},
                  tag_t'{16'h0000, 3'd0, 2'd0, 1'b1},
                  tag_t'{16'h0000, 3'd0, 2'd1, 1'b0},
                  tag_t'{16'h0000, 3'd1, 2'd0, 1'b0},
                  tag_t'{16'h0001, 3'd0, 2'd0, 1'b0},
                  tag_t'{16'hFFFE, 3'd7, 2'd3, 1'b1},
                  tag_t'{16'h8000, 3'd7, 2'd3, 1'b1},
                  tag_t'{16'hFFFE, 3'd7, 2'd3, 1'b0},
                  tag_t'{16'h5555, 3'd2, 2'd2, 1'b1}};
    write_atlas_count(16'hFFFF);
    foreach (fill_tags[i]) send_request(lookup_req(fill_tags[i]));
    send_request(lookup_req(fill_tags[0]));
  endtask

  // Oldest stamp goes first; lowest slot wins a tie
  task automatic test_lru_eviction();
    send_request(frame_req());
    send_request(lookup_req(tag_t'{16'h1234, 3'd5, 2'd1, 1'b0}));
    send_request(lookup_req(tag_t'{16'h0000, 3'd1, 2'd0, 1'b0}));
    send_request(frame_req());
    send_request(lookup_req(tag_t'{16'h4321, 3'd6, 2'd2, 1'b1}));
  endtask

  // Hits ignore the atlas limit; misses past it are rejected
  task automatic test_atlas_limit();
    write_atlas_count(16'd2);
    send_request(lookup_req(tag_t'{16'hFFFE, 3'd7, 2'd3, 1'b1}));
    send_request(lookup_req(tag_t'{16'h0002, 3'd3, 2'd1, 1'b0}));
    send_request(lookup_req(tag_t'{16'h0001, 3'd4, 2'd2, 1'b1}));
    send_request(lookup_req(tag_t'{16'hFFFF, 3'd0, 2'd0, 1'b0}));
  endtask

  // Working set a bit larger than the cache, frame requests sprinkled in
  task automatic test_random_traffic(logic [15:0] limit, int n_items, bit gaps);
    int r;
    write_atlas_count(limit);
    gap_enable = gaps;
    for (int k = 0; k < POOL_SIZE; k++) begin
      if ($urandom_range(0, 2) == 0) page_pool[k] = random_page(limit);
    end
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 12) send_request(frame_req());
      else if (r < 88) send_request(lookup_req(page_pool[$urandom_range(0, POOL_SIZE - 1)]));
      else send_request(lookup_req(random_page(limit)));
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_tag[i]   = '0;
      slot_stamp[i] = '0;
    end
    frame_count = 32'd1;
    atlas_limit = 16'd0;
    for (int k = 0; k < POOL_SIZE; k++) page_pool[k] = random_page(16'hFFFF);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_fill_and_pin();
    test_lru_eviction();
    test_atlas_limit();
    test_random_traffic(16'hFFFF, 300, 1'b1);
    test_random_traffic(16'h0000, 200, 1'b1);
    test_random_traffic(16'($urandom), 300, 1'b0);
    test_random_traffic(16'h0001, 200, 1'b1);
    test_random_traffic(16'h8000, 300, 1'b1);
    test_random_traffic(16'd12, 300, 1'b1);

    drain_results();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
